@@ rtl/core/fstw_pkg.sv @@
// Shared types and constants for the device tree structure block token walker.
// Used by every module under rtl/core; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package fstw_pkg;

  localparam int CFG_W       = 21;
  localparam int WORD_W      = 32;
  localparam int DEPTH_OUT_W = 6;
  localparam int CELL_IDX_W  = 20;
  // Cell count of a property is at most 2^30, so it needs one bit more.
  localparam int CELLS_W     = 31;

  localparam logic [WORD_W-1:0] TOK_BEGIN_NODE = 32'd1;
  localparam logic [WORD_W-1:0] TOK_END_NODE   = 32'd2;
  localparam logic [WORD_W-1:0] TOK_PROP       = 32'd3;
  localparam logic [WORD_W-1:0] TOK_NOP        = 32'd4;
  localparam logic [WORD_W-1:0] TOK_END        = 32'd9;

  typedef enum logic [5:0] {
    PH_TOKEN   = 6'b000001,
    PH_NAME    = 6'b000010,
    PH_LEN     = 6'b000100,
    PH_NAMEOFF = 6'b001000,
    PH_CELLS   = 6'b010000,
    PH_HALT    = 6'b100000
  } phase_e;

  typedef enum logic [3:0] {
    EV_BUSY    = 4'd0,
    EV_BEGIN   = 4'd1,
    EV_ENDNODE = 4'd2,
    EV_HEADER  = 4'd3,
    EV_CELL    = 4'd4,
    EV_END     = 4'd5,
    EV_NOP     = 4'd6,
    EV_BADTOK  = 4'd7,
    EV_OVERRUN = 4'd8,
    EV_DEPTH   = 4'd9
  } event_e;

  typedef struct packed {
    logic              valid;
    logic              first;
    logic [WORD_W-1:0] word;
  } item_t;

  typedef struct packed {
    event_e                 ev;
    logic [DEPTH_OUT_W-1:0] depth;
    logic [DEPTH_OUT_W-1:0] peak_depth;
    logic [WORD_W-1:0]      prop_length;
    logic [WORD_W-1:0]      str_offset;
    logic [WORD_W-1:0]      cell_value;
    logic [CELL_IDX_W-1:0]  cell_index;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/fdt_structure_token_walker.sv @@
// Top level of the device tree structure block token walker.
// Depends on fstw_pkg, fstw_in_stage and fstw_walk.
`timescale 1ns / 1ps
`default_nettype none

// Takes one big-endian structure block word per request and gives exactly one result per
// word. A word is held in the input register and its result is captured in the output
// register when the word moves on; a new word is taken every cycle as
// long as the result side keeps up; the walk state updates once per word in a single pass.
// A word with first_word_i set restarts the walk. The block size register must be written
// while no word is in flight; sizes above MAX_WORDS are treated as MAX_WORDS.
module fdt_structure_token_walker #(
  parameter int MAX_DEPTH = 32,
  parameter int MAX_WORDS = 1048576
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [fstw_pkg::CFG_W-1:0]      cfg_struct_size_words_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [fstw_pkg::WORD_W-1:0]     word_i,
  input  wire logic                            first_word_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [3:0]                           event_res_o,
  output logic [fstw_pkg::DEPTH_OUT_W-1:0]     depth_o,
  output logic [fstw_pkg::DEPTH_OUT_W-1:0]     peak_depth_o,
  output logic [fstw_pkg::WORD_W-1:0]          prop_length_o,
  output logic [fstw_pkg::WORD_W-1:0]          str_offset_o,
  output logic [fstw_pkg::WORD_W-1:0]          cell_value_o,
  output logic [fstw_pkg::CELL_IDX_W-1:0]      cell_index_o
);

  localparam int PW = $clog2(MAX_WORDS + 1);
  localparam int XW = (PW > fstw_pkg::CFG_W) ? PW : fstw_pkg::CFG_W;

  logic [fstw_pkg::CFG_W-1:0] size_cfg_q;
  logic [XW-1:0]              size_ext;
  logic [PW-1:0]              size_eff;
  fstw_pkg::item_t            item;
  fstw_pkg::result_t          res;
  fstw_pkg::result_t          res_q;
  logic                       out_valid_q;
  logic                       advance;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_cfg_q <= '0;
    end else if (cfg_valid_i) begin
      size_cfg_q <= cfg_struct_size_words_i;
    end
  end

  assign size_ext = (XW'(size_cfg_q) > XW'(MAX_WORDS)) ? XW'(MAX_WORDS) : XW'(size_cfg_q);
  assign size_eff = size_ext[PW-1:0];

  // A word moves on when the output register is empty or is being emptied.
  assign advance = item.valid && (!out_valid_q || out_ready_i);

  fstw_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .word_i       (word_i),
    .first_word_i (first_word_i),
    .take_i       (advance),
    .item_o       (item)
  );

  fstw_walk #(
    .MAX_DEPTH (MAX_DEPTH),
    .MAX_WORDS (MAX_WORDS)
  ) u_walk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (item),
    .size_i   (size_eff),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_res_o   = res_q.ev;
  assign depth_o       = res_q.depth;
  assign peak_depth_o  = res_q.peak_depth;
  assign prop_length_o = res_q.prop_length;
  assign str_offset_o  = res_q.str_offset;
  assign cell_value_o  = res_q.cell_value;
  assign cell_index_o  = res_q.cell_index;

endmodule

`default_nettype wire

@@ rtl/core/fstw_in_stage.sv @@
// Input register for the token walker: holds one structure word and its restart flag.
// Depends on fstw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fstw_in_stage (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [fstw_pkg::WORD_W-1:0] word_i,
  input  wire logic                       first_word_i,
  input  wire logic                       take_i,
  output fstw_pkg::item_t                 item_o
);

  logic                        valid_q;
  logic                        first_q;
  logic [fstw_pkg::WORD_W-1:0] word_q;

  // The held word may be replaced in the same cycle in which it moves on.
  assign in_ready_o = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      first_q <= first_word_i;
      word_q  <= word_i;
    end
  end

  assign item_o.valid = valid_q;
  assign item_o.first = first_q;
  assign item_o.word  = word_q;

endmodule

`default_nettype wire

@@ rtl/core/fstw_walk.sv @@
// Walk state and the per-word decode of the structure block tokens.
// Depends on fstw_pkg; driven from the input register, feeds the result register.
`timescale 1ns / 1ps
`default_nettype none

module fstw_walk #(
  parameter int MAX_DEPTH = 32,
  parameter int MAX_WORDS = 1048576,
  localparam int PW = $clog2(MAX_WORDS + 1),
  localparam int DW = $clog2(MAX_DEPTH + 1)
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           step_i,
  input  wire fstw_pkg::item_t item_i,
  input  wire logic [PW-1:0]  size_i,
  output fstw_pkg::result_t   result_o
);

  localparam int SUMW = ((PW > fstw_pkg::CELLS_W) ? PW : fstw_pkg::CELLS_W) + 1;

  fstw_pkg::phase_e                  phase_q, phase_d, eff_phase;
  logic [DW-1:0]                     open_q, open_d, eff_open;
  logic [DW-1:0]                     deep_q, deep_d, eff_deep;
  logic [PW-1:0]                     pos_q, pos_d, eff_pos, next_pos;
  logic [fstw_pkg::CELLS_W-1:0]      cl_q, cl_d, eff_cl, cells, cl_dec;
  logic [fstw_pkg::CELL_IDX_W-1:0]   cc_q, cc_d, eff_cc;
  logic [fstw_pkg::WORD_W-1:0]       hl_q, hl_d, eff_hl;
  logic [fstw_pkg::WORD_W-1:0]       hn_q, hn_d, eff_hn;
  logic [SUMW-1:0]                   span;
  logic                              last_word;
  logic                              zero_byte;
  logic [fstw_pkg::WORD_W-1:0]       word;
  fstw_pkg::result_t                 res;

  assign word = item_i.word;

  // A restart word sees the walk as if it had just come out of reset.
  always_comb begin
    eff_phase = item_i.first ? fstw_pkg::PH_TOKEN : phase_q;
    eff_open  = item_i.first ? '0 : open_q;
    eff_deep  = item_i.first ? '0 : deep_q;
    eff_pos   = item_i.first ? '0 : pos_q;
    eff_cl    = item_i.first ? '0 : cl_q;
    eff_cc    = item_i.first ? '0 : cc_q;
    eff_hl    = item_i.first ? '0 : hl_q;
    eff_hn    = item_i.first ? '0 : hn_q;
  end

  assign next_pos  = eff_pos + PW'(1);
  assign last_word = next_pos >= size_i;
  assign zero_byte = (word[31:24] == 8'd0) || (word[23:16] == 8'd0) ||
                     (word[15:8] == 8'd0) || (word[7:0] == 8'd0);
  assign cells     = fstw_pkg::CELLS_W'(eff_hl[31:2]) +
                     fstw_pkg::CELLS_W'(|eff_hl[1:0]);
  // The property and all of its cells must leave room for a following token.
  assign span      = SUMW'(next_pos) + SUMW'(cells);
  assign cl_dec    = (eff_cl != '0) ? eff_cl - fstw_pkg::CELLS_W'(1) : eff_cl;

  always_comb begin
    phase_d = eff_phase;
    open_d  = eff_open;
    deep_d  = eff_deep;
    pos_d   = eff_pos;
    cl_d    = eff_cl;
    cc_d    = eff_cc;
    hl_d    = eff_hl;
    hn_d    = eff_hn;
    res     = '0;
    res.ev  = fstw_pkg::EV_BUSY;

    if (eff_phase != fstw_pkg::PH_HALT) begin
      if (eff_pos >= size_i) begin
        res.ev  = fstw_pkg::EV_OVERRUN;
        phase_d = fstw_pkg::PH_HALT;
      end else begin
        pos_d = next_pos;
        case (eff_phase)
          fstw_pkg::PH_TOKEN: begin
            case (word)
              fstw_pkg::TOK_BEGIN_NODE: begin
                res.depth = fstw_pkg::DEPTH_OUT_W'(eff_open);
                if (eff_open >= DW'(MAX_DEPTH)) begin
                  res.ev  = fstw_pkg::EV_DEPTH;
                  phase_d = fstw_pkg::PH_HALT;
                end else begin
                  res.ev  = fstw_pkg::EV_BEGIN;
                  if (eff_open > eff_deep) begin
                    deep_d = eff_open;
                  end
                  open_d  = eff_open + DW'(1);
                  phase_d = fstw_pkg::PH_NAME;
                end
              end
              fstw_pkg::TOK_END_NODE: begin
                if (eff_open == '0) begin
                  res.ev  = fstw_pkg::EV_DEPTH;
                  phase_d = fstw_pkg::PH_HALT;
                end else if (last_word) begin
                  res.ev  = fstw_pkg::EV_OVERRUN;
                  phase_d = fstw_pkg::PH_HALT;
                end else begin
                  open_d    = eff_open - DW'(1);
                  res.ev    = fstw_pkg::EV_ENDNODE;
                  res.depth = fstw_pkg::DEPTH_OUT_W'(eff_open - DW'(1));
                end
              end
              fstw_pkg::TOK_PROP: begin
                phase_d = fstw_pkg::PH_LEN;
              end
              fstw_pkg::TOK_NOP: begin
                if (last_word) begin
                  res.ev  = fstw_pkg::EV_OVERRUN;
                  phase_d = fstw_pkg::PH_HALT;
                end else begin
                  res.ev = fstw_pkg::EV_NOP;
                end
              end
              fstw_pkg::TOK_END: begin
                res.ev  = fstw_pkg::EV_END;
                phase_d = fstw_pkg::PH_HALT;
              end
              default: begin
                res.ev  = fstw_pkg::EV_BADTOK;
                phase_d = fstw_pkg::PH_HALT;
              end
            endcase
          end
          fstw_pkg::PH_NAME: begin
            if (zero_byte) begin
              if (last_word) begin
                res.ev  = fstw_pkg::EV_OVERRUN;
                phase_d = fstw_pkg::PH_HALT;
              end else begin
                phase_d = fstw_pkg::PH_TOKEN;
              end
            end
          end
          fstw_pkg::PH_LEN: begin
            hl_d    = word;
            phase_d = fstw_pkg::PH_NAMEOFF;
          end
          fstw_pkg::PH_NAMEOFF: begin
            hn_d = word;
            if (span >= SUMW'(size_i)) begin
              res.ev  = fstw_pkg::EV_OVERRUN;
              phase_d = fstw_pkg::PH_HALT;
            end else begin
              res.ev          = fstw_pkg::EV_HEADER;
              res.prop_length = eff_hl;
              res.str_offset  = word;
              cl_d            = cells;
              cc_d            = '0;
              phase_d         = (cells != '0) ? fstw_pkg::PH_CELLS : fstw_pkg::PH_TOKEN;
            end
          end
          fstw_pkg::PH_CELLS: begin
            res.ev          = fstw_pkg::EV_CELL;
            res.prop_length = eff_hl;
            res.str_offset  = eff_hn;
            res.cell_value  = word;
            res.cell_index  = eff_cc;
            cc_d            = eff_cc + fstw_pkg::CELL_IDX_W'(1);
            cl_d            = cl_dec;
            if (cl_dec == '0) begin
              phase_d = fstw_pkg::PH_TOKEN;
            end
          end
          default: begin
            phase_d = fstw_pkg::PH_HALT;
          end
        endcase
      end
    end
    res.peak_depth = fstw_pkg::DEPTH_OUT_W'(deep_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= fstw_pkg::PH_TOKEN;
      open_q  <= '0;
      deep_q  <= '0;
      pos_q   <= '0;
      cl_q    <= '0;
      cc_q    <= '0;
      hl_q    <= '0;
      hn_q    <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      open_q  <= open_d;
      deep_q  <= deep_d;
      pos_q   <= pos_d;
      cl_q    <= cl_d;
      cc_q    <= cc_d;
      hl_q    <= hl_d;
      hn_q    <= hn_d;
    end
  end

  assign result_o = res;

endmodule

`default_nettype wire

@@ rtl/core/fstw_checker.sv @@
// Port-level checks for the token walker, attached to the top level by bind.
// Depends on fstw_pkg and fdt_structure_token_walker.
`timescale 1ns / 1ps
`default_nettype none

module fstw_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                out_valid_o,
  input wire logic                                out_ready_i,
  input wire logic [3:0]                          event_res_o,
  input wire logic [fstw_pkg::DEPTH_OUT_W-1:0]    depth_o,
  input wire logic [fstw_pkg::DEPTH_OUT_W-1:0]    peak_depth_o,
  input wire logic [fstw_pkg::WORD_W-1:0]         prop_length_o,
  input wire logic [fstw_pkg::WORD_W-1:0]         str_offset_o,
  input wire logic [fstw_pkg::WORD_W-1:0]         cell_value_o,
  input wire logic [fstw_pkg::CELL_IDX_W-1:0]     cell_index_o
);

  // A stalled result keeps its valid and its whole payload.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(event_res_o) &&
      $stable(depth_o) && $stable(peak_depth_o) && $stable(prop_length_o) &&
      $stable(str_offset_o) && $stable(cell_value_o) && $stable(cell_index_o))
    else $error("result changed while stalled");

  // A node that begins or ends was counted in the deepest level seen.
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_res_o == fstw_pkg::EV_BEGIN || event_res_o == fstw_pkg::EV_ENDNODE)
      |-> depth_o <= peak_depth_o)
    else $error("node depth above greatest depth");

  a_cell_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o != fstw_pkg::EV_CELL |-> cell_value_o == '0 && cell_index_o == '0)
    else $error("cell fields set outside a property cell");

  a_prop_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o != fstw_pkg::EV_CELL && event_res_o != fstw_pkg::EV_HEADER
      |-> prop_length_o == '0 && str_offset_o == '0)
    else $error("property fields set outside a property");

endmodule

bind fdt_structure_token_walker fstw_checker u_fstw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .event_res_o   (event_res_o),
  .depth_o       (depth_o),
  .peak_depth_o  (peak_depth_o),
  .prop_length_o (prop_length_o),
  .str_offset_o  (str_offset_o),
  .cell_value_o  (cell_value_o),
  .cell_index_o  (cell_index_o)
);

`default_nettype wire
